@@ design/irc_message_tokenizer_top_macros.svh @@
// Assertion macros used by the IRC message tokenizer RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef IRC_MESSAGE_TOKENIZER_TOP_MACROS_SVH
`define IRC_MESSAGE_TOKENIZER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define IRC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define IRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/irc_tok_pkg.sv @@
// Shared types and constants for the IRC message tokenizer.
// No dependencies; used by irc_tok_parse and irc_message_tokenizer_top.
package irc_tok_pkg;

    // Parameter count limit and the saturation point of the parameter index
    localparam int unsigned MAX_PARAMS = 15;
    localparam int unsigned PARAM_CAP_INT = (MAX_PARAMS < 15) ? MAX_PARAMS : 15;
    localparam logic [3:0] PARAM_CAP = 4'(PARAM_CAP_INT);

    // Command digit limit; the counter saturates one above it
    localparam logic [2:0] DIGIT_LIMIT = 3'd3;
    localparam logic [2:0] DIGIT_SAT = DIGIT_LIMIT + 3'd1;

    // Field kind codes
    localparam logic [3:0] KIND_SEP       = 4'd0;
    localparam logic [3:0] KIND_NICK      = 4'd1;
    localparam logic [3:0] KIND_USER      = 4'd2;
    localparam logic [3:0] KIND_HOST      = 4'd3;
    localparam logic [3:0] KIND_CMD_LETTER = 4'd4;
    localparam logic [3:0] KIND_CMD_DIGIT = 4'd5;
    localparam logic [3:0] KIND_MIDDLE    = 4'd6;
    localparam logic [3:0] KIND_TRAILING  = 4'd7;
    localparam logic [3:0] KIND_LINE_END  = 4'd8;

    // Special characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;

    // Tags for one byte
    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] pnum;
        logic       start;
        logic       bad;
        logic       many;
        logic       done;
    } t_result;

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_nick_char(input logic [7:0] b);
        return is_letter(b) || is_digit(b) || b == 8'h2D || b == 8'h5B || b == 8'h5D ||
               b == 8'h5C || b == 8'h60 || b == 8'h5E || b == 8'h7B || b == 8'h7D ||
               b == 8'h2E;
    endfunction

    function automatic logic is_gap(input logic [7:0] b);
        return b == CH_SPACE || b == CH_NUL;
    endfunction

endpackage

@@ design/irc_tok_parse.sv @@
// Parse state of the IRC tokenizer and the per-byte tagging logic.
// Depends on irc_tok_pkg; instantiated by irc_message_tokenizer_top.
module irc_tok_parse (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    output irc_tok_pkg::t_result  o_result
);

    typedef enum logic [3:0] {
        PH_START       = 4'd0,
        PH_NICK_FIRST  = 4'd1,
        PH_NICK        = 4'd2,
        PH_USER_FIRST  = 4'd3,
        PH_USER        = 4'd4,
        PH_HOST_FIRST  = 4'd5,
        PH_HOST        = 4'd6,
        PH_GAP         = 4'd7,
        PH_CMD_START   = 4'd8,
        PH_CMD_LETTERS = 4'd9,
        PH_CMD_DIGITS  = 4'd10,
        PH_SEP         = 4'd11,
        PH_MIDDLE      = 4'd12,
        PH_TRAIL_FIRST = 4'd13,
        PH_TRAIL       = 4'd14
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [2:0] r_digits, n_digits;
    logic [3:0] r_pidx, n_pidx;
    logic       r_cr, n_cr;

    // Byte classes
    logic gap, colon, letter, digit;

    // Parameter-section outcome
    t_phase     ps_phase;
    logic [3:0] ps_kind;
    logic       ps_start;

    // Command-start outcome
    t_phase     cs_phase;
    logic [3:0] cs_kind;
    logic       cs_start;
    logic [2:0] cs_digits;

    irc_tok_pkg::t_result res;

    assign gap    = irc_tok_pkg::is_gap(i_byte);
    assign colon  = (i_byte == irc_tok_pkg::CH_COLON);
    assign letter = irc_tok_pkg::is_letter(i_byte);
    assign digit  = irc_tok_pkg::is_digit(i_byte);

    // Classify a byte in the parameter section
    always_comb begin
        priority if (gap) begin
            ps_kind  = irc_tok_pkg::KIND_SEP;
            ps_start = 1'b0;
            ps_phase = PH_SEP;
        end else if (colon) begin
            ps_kind  = irc_tok_pkg::KIND_SEP;
            ps_start = 1'b0;
            ps_phase = PH_TRAIL_FIRST;
        end else begin
            ps_kind  = irc_tok_pkg::KIND_MIDDLE;
            ps_start = 1'b1;
            ps_phase = PH_MIDDLE;
        end
    end

    // Classify a byte where the command is expected to open
    always_comb begin
        cs_digits = r_digits;
        priority if (letter) begin
            cs_kind  = irc_tok_pkg::KIND_CMD_LETTER;
            cs_start = 1'b1;
            cs_phase = PH_CMD_LETTERS;
        end else if (digit) begin
            cs_kind   = irc_tok_pkg::KIND_CMD_DIGIT;
            cs_start  = 1'b1;
            cs_phase  = PH_CMD_DIGITS;
            cs_digits = 3'd1;
        end else begin
            cs_kind  = ps_kind;
            cs_start = ps_start;
            cs_phase = ps_phase;
        end
    end

    // Tag the byte and work out the next parse state
    always_comb begin
        n_phase  = r_phase;
        n_digits = r_digits;
        n_pidx   = r_pidx;
        n_cr     = 1'b0;
        res      = '0;

        priority if (i_byte == irc_tok_pkg::CH_LF) begin
            res.kind = irc_tok_pkg::KIND_LINE_END;
            if (r_cr) begin
                res.done = 1'b1;
                n_phase  = PH_START;
                n_digits = '0;
                n_pidx   = '0;
            end
        end else if (i_byte == irc_tok_pkg::CH_CR) begin
            res.kind = irc_tok_pkg::KIND_LINE_END;
            n_cr     = 1'b1;
        end else begin
            unique case (r_phase)
                PH_NICK_FIRST, PH_NICK: begin
                    if ((r_phase == PH_NICK_FIRST && letter) ||
                        (r_phase == PH_NICK && irc_tok_pkg::is_nick_char(i_byte))) begin
                        res.kind  = irc_tok_pkg::KIND_NICK;
                        res.start = (r_phase == PH_NICK_FIRST);
                        n_phase   = PH_NICK;
                    end else begin
                        priority if (i_byte == irc_tok_pkg::CH_BANG) begin
                            n_phase = PH_USER_FIRST;
                        end else if (i_byte == irc_tok_pkg::CH_AT) begin
                            n_phase = PH_HOST_FIRST;
                        end else begin
                            n_phase = PH_GAP;
                        end
                    end
                end
                PH_USER_FIRST, PH_USER: begin
                    priority if (i_byte == irc_tok_pkg::CH_AT) begin
                        n_phase = PH_HOST_FIRST;
                    end else if (gap) begin
                        n_phase = PH_GAP;
                    end else begin
                        res.kind  = irc_tok_pkg::KIND_USER;
                        res.start = (r_phase == PH_USER_FIRST);
                        n_phase   = PH_USER;
                    end
                end
                PH_HOST_FIRST, PH_HOST: begin
                    if (gap) begin
                        n_phase = PH_GAP;
                    end else begin
                        res.kind  = irc_tok_pkg::KIND_HOST;
                        res.start = (r_phase == PH_HOST_FIRST);
                        n_phase   = PH_HOST;
                    end
                end
                PH_GAP, PH_CMD_START: begin
                    if (!(r_phase == PH_GAP && gap)) begin
                        res.kind  = cs_kind;
                        res.start = cs_start;
                        res.bad   = !letter;
                        res.pnum  = (cs_kind == irc_tok_pkg::KIND_MIDDLE) ? r_pidx : 4'd0;
                        n_phase   = cs_phase;
                        n_digits  = cs_digits;
                    end
                end
                PH_CMD_LETTERS: begin
                    priority if (letter) begin
                        res.kind = irc_tok_pkg::KIND_CMD_LETTER;
                    end else if (digit) begin
                        res.kind  = irc_tok_pkg::KIND_CMD_DIGIT;
                        res.start = 1'b1;
                        n_digits  = 3'd1;
                        n_phase   = PH_CMD_DIGITS;
                    end else begin
                        res.kind  = ps_kind;
                        res.start = ps_start;
                        res.pnum  = ps_start ? r_pidx : 4'd0;
                        n_phase   = ps_phase;
                    end
                end
                PH_CMD_DIGITS: begin
                    if (digit) begin
                        res.kind = irc_tok_pkg::KIND_CMD_DIGIT;
                        res.many = (r_digits >= irc_tok_pkg::DIGIT_LIMIT);
                        if (r_digits < irc_tok_pkg::DIGIT_SAT) begin
                            n_digits = r_digits + 3'd1;
                        end
                    end else begin
                        res.kind  = ps_kind;
                        res.start = ps_start;
                        res.pnum  = ps_start ? r_pidx : 4'd0;
                        n_phase   = ps_phase;
                    end
                end
                PH_SEP: begin
                    res.kind  = ps_kind;
                    res.start = ps_start;
                    res.pnum  = ps_start ? r_pidx : 4'd0;
                    n_phase   = ps_phase;
                end
                PH_MIDDLE: begin
                    if (gap) begin
                        if (r_pidx < irc_tok_pkg::PARAM_CAP) begin
                            n_pidx = r_pidx + 4'd1;
                        end
                        n_phase = PH_SEP;
                    end else begin
                        res.kind = irc_tok_pkg::KIND_MIDDLE;
                        res.pnum = r_pidx;
                    end
                end
                PH_TRAIL_FIRST, PH_TRAIL: begin
                    if (i_byte != irc_tok_pkg::CH_NUL) begin
                        res.kind  = irc_tok_pkg::KIND_TRAILING;
                        res.pnum  = r_pidx;
                        res.start = (r_phase == PH_TRAIL_FIRST);
                        n_phase   = PH_TRAIL;
                    end
                end
                default: begin
                    // Start of message: optional prefix, else the command
                    if (colon) begin
                        n_phase = PH_NICK_FIRST;
                    end else begin
                        res.kind  = cs_kind;
                        res.start = cs_start;
                        res.bad   = !letter;
                        res.pnum  = (cs_kind == irc_tok_pkg::KIND_MIDDLE) ? r_pidx : 4'd0;
                        n_phase   = cs_phase;
                        n_digits  = cs_digits;
                    end
                end
            endcase
        end
    end

    assign o_result = res;

    // Hold the parse state; advance it on each byte moved to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_digits <= '0;
            r_pidx   <= '0;
            r_cr     <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_digits <= n_digits;
            r_pidx   <= n_pidx;
            r_cr     <= n_cr;
        end
    end

endmodule

@@ design/irc_message_tokenizer_top.sv @@
// IRC message tokenizer top level: input register, tagging logic, result register.
// A byte is registered in the input stage, tagged by the parse logic and registered in the
// result stage, from which it transfers (input stage, result stage).
// Throughput: one byte per cycle while the result side does not stall; the parse state advances with each byte.
// Reset (i_rst_n, synchronous, active low) empties both stages and returns the parse
// to the start of a message. Depends on irc_tok_pkg and irc_tok_parse.
`include "irc_message_tokenizer_top_macros.svh"

module irc_message_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_char_out,
    output logic [3:0] o_field_kind,
    output logic [3:0] o_param_number,
    output logic       o_field_start,
    output logic       o_bad_command,
    output logic       o_too_many_digits,
    output logic       o_message_done
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    irc_tok_pkg::t_result r_out_res;

    irc_tok_pkg::t_result parse_res;
    logic advance;
    logic in_take;

    // Move the held byte on when the result stage is empty or being drained
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    irc_tok_parse u_parse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_byte    (r_in_byte),
        .o_result  (parse_res)
    );

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
        end
    end

    // Result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= r_in_byte;
            r_out_res  <= parse_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_char_out        = r_out_byte;
    assign o_field_kind      = r_out_res.kind;
    assign o_param_number    = r_out_res.pnum;
    assign o_field_start     = r_out_res.start;
    assign o_bad_command     = r_out_res.bad;
    assign o_too_many_digits = r_out_res.many;
    assign o_message_done    = r_out_res.done;

    // Consistency between tags and the transferred byte
    `IRC_ASSERT_NOW(a_done_on_lf, i_clk, i_rst_n, o_valid && o_message_done, o_char_out == irc_tok_pkg::CH_LF && o_field_kind == irc_tok_pkg::KIND_LINE_END, "message_done without LF line end")
    `IRC_ASSERT_NOW(a_start_kind, i_clk, i_rst_n, o_valid && o_field_start, o_field_kind != irc_tok_pkg::KIND_SEP && o_field_kind != irc_tok_pkg::KIND_LINE_END, "field_start on separator or line end")
    `IRC_ASSERT_NOW(a_pnum_kind, i_clk, i_rst_n, o_valid && o_param_number != 4'd0, o_field_kind == irc_tok_pkg::KIND_MIDDLE || o_field_kind == irc_tok_pkg::KIND_TRAILING, "parameter number on a non-parameter byte")
    `IRC_ASSERT_NOW(a_many_digit, i_clk, i_rst_n, o_valid && o_too_many_digits, o_field_kind == irc_tok_pkg::KIND_CMD_DIGIT && !o_field_start, "digit overflow outside command digits")
    `IRC_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, advance, o_valid && $past(r_in_byte) == o_char_out, "advanced byte missing from result stage")

endmodule

@@ dv/irc_message_tokenizer_checker.sv @@
// Checker for the IRC message tokenizer: watches both transfer channels,
// predicts the tags of every accepted byte and compares each result field.
// Depends on irc_tok_pkg for the field kind codes and the parse limits.
module irc_message_tokenizer_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_char,
    input  logic [3:0] i_kind,
    input  logic [3:0] i_pnum,
    input  logic       i_start,
    input  logic       i_bad,
    input  logic       i_many,
    input  logic       i_done,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [3:0] {
        MSG_START, NICK_HEAD, NICK_BODY, USER_HEAD, USER_BODY, HOST_HEAD, HOST_BODY,
        CMD_GAP, CMD_LETTERS, CMD_DIGITS, PARAM_GAP, MIDDLE_BODY, TRAIL_HEAD, TRAIL_BODY
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic [3:0] kind;
        logic [3:0] pnum;
        logic       start;
        logic       bad;
        logic       many;
        logic       done;
    } t_tag;

    // Parse state of the prediction
    t_phase     phase;
    logic [2:0] digit_count;
    logic [3:0] param_idx;
    logic       cr_seen;

    t_tag tag_q[$];
    int   result_no;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic is_num(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    // NUL counts as a space everywhere but inside a trailing parameter
    function automatic logic is_blank(input logic [7:0] b);
        return b == irc_tok_pkg::CH_SPACE || b == irc_tok_pkg::CH_NUL;
    endfunction

    // Parameter section: skip gaps, ':' opens trailing, anything else a middle
    function automatic void open_param(input logic [7:0] b, inout t_tag t);
        phase = PARAM_GAP;
        if (is_blank(b)) begin
            t.kind = irc_tok_pkg::KIND_SEP;
        end else if (b == irc_tok_pkg::CH_COLON) begin
            t.kind = irc_tok_pkg::KIND_SEP;
            phase = TRAIL_HEAD;
        end else begin
            t.kind = irc_tok_pkg::KIND_MIDDLE;
            t.start = 1'b1;
            t.pnum = param_idx;
            phase = MIDDLE_BODY;
        end
    endfunction

    // First command byte: a letter is expected, a digit opens the digit part
    function automatic void open_command(input logic [7:0] b, inout t_tag t);
        if (is_alpha(b)) begin
            t.kind = irc_tok_pkg::KIND_CMD_LETTER;
            t.start = 1'b1;
            phase = CMD_LETTERS;
        end else if (is_num(b)) begin
            t.kind = irc_tok_pkg::KIND_CMD_DIGIT;
            t.start = 1'b1;
            t.bad = 1'b1;
            digit_count = 3'd1;
            phase = CMD_DIGITS;
        end else begin
            t.bad = 1'b1;
            open_param(b, t);
        end
    endfunction

    // Byte that ends the nick: '!' to user, '@' to host, else end of prefix
    function automatic void close_nick(input logic [7:0] b, inout t_tag t);
        t.kind = irc_tok_pkg::KIND_SEP;
        if (b == irc_tok_pkg::CH_BANG) phase = USER_HEAD;
        else if (b == irc_tok_pkg::CH_AT) phase = HOST_HEAD;
        else phase = CMD_GAP;
    endfunction

    function automatic t_tag tag_byte(input logic [7:0] b);
        t_tag t;
        t = '0;
        t.ch = b;
        t.kind = irc_tok_pkg::KIND_SEP;
        if (b == irc_tok_pkg::CH_LF) begin
            // LF closes the message only straight after a CR
            t.kind = irc_tok_pkg::KIND_LINE_END;
            if (cr_seen) begin
                t.done = 1'b1;
                phase = MSG_START;
                digit_count = '0;
                param_idx = '0;
            end
            cr_seen = 1'b0;
        end else if (b == irc_tok_pkg::CH_CR) begin
            t.kind = irc_tok_pkg::KIND_LINE_END;
            cr_seen = 1'b1;
        end else begin
            cr_seen = 1'b0;
            case (phase)
                NICK_HEAD: begin
                    if (is_alpha(b)) begin
                        t.kind = irc_tok_pkg::KIND_NICK;
                        t.start = 1'b1;
                        phase = NICK_BODY;
                    end else begin
                        close_nick(b, t);
                    end
                end
                NICK_BODY: begin
                    // letters, digits and - [ ] \ ` ^ { } .
                    if (is_alpha(b) || is_num(b) || b == 8'h2D || b == 8'h5B ||
                        b == 8'h5D || b == 8'h5C || b == 8'h60 || b == 8'h5E ||
                        b == 8'h7B || b == 8'h7D || b == 8'h2E) begin
                        t.kind = irc_tok_pkg::KIND_NICK;
                    end else begin
                        close_nick(b, t);
                    end
                end
                USER_HEAD, USER_BODY: begin
                    if (b == irc_tok_pkg::CH_AT) begin
                        phase = HOST_HEAD;
                    end else if (is_blank(b)) begin
                        phase = CMD_GAP;
                    end else begin
                        t.kind = irc_tok_pkg::KIND_USER;
                        t.start = (phase == USER_HEAD);
                        phase = USER_BODY;
                    end
                end
                HOST_HEAD, HOST_BODY: begin
                    if (is_blank(b)) begin
                        phase = CMD_GAP;
                    end else begin
                        t.kind = irc_tok_pkg::KIND_HOST;
                        t.start = (phase == HOST_HEAD);
                        phase = HOST_BODY;
                    end
                end
                CMD_GAP: begin
                    if (!is_blank(b)) open_command(b, t);
                end
                CMD_LETTERS: begin
                    if (is_alpha(b)) begin
                        t.kind = irc_tok_pkg::KIND_CMD_LETTER;
                    end else if (is_num(b)) begin
                        t.kind = irc_tok_pkg::KIND_CMD_DIGIT;
                        t.start = 1'b1;
                        digit_count = 3'd1;
                        phase = CMD_DIGITS;
                    end else begin
                        open_param(b, t);
                    end
                end
                CMD_DIGITS: begin
                    if (is_num(b)) begin
                        t.kind = irc_tok_pkg::KIND_CMD_DIGIT;
                        if (digit_count >= irc_tok_pkg::DIGIT_LIMIT) t.many = 1'b1;
                        if (digit_count < irc_tok_pkg::DIGIT_SAT)
                            digit_count = digit_count + 3'd1;
                    end else begin
                        open_param(b, t);
                    end
                end
                PARAM_GAP: open_param(b, t);
                MIDDLE_BODY: begin
                    if (is_blank(b)) begin
                        if (param_idx < irc_tok_pkg::PARAM_CAP) param_idx = param_idx + 4'd1;
                        phase = PARAM_GAP;
                    end else begin
                        t.kind = irc_tok_pkg::KIND_MIDDLE;
                        t.pnum = param_idx;
                    end
                end
                TRAIL_HEAD, TRAIL_BODY: begin
                    if (b != irc_tok_pkg::CH_NUL) begin
                        t.kind = irc_tok_pkg::KIND_TRAILING;
                        t.pnum = param_idx;
                        t.start = (phase == TRAIL_HEAD);
                        phase = TRAIL_BODY;
                    end
                end
                default: begin
                    if (b == irc_tok_pkg::CH_COLON) phase = NICK_HEAD;
                    else open_command(b, t);
                end
            endcase
        end
        return t;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("%0t checker: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_no, name, got, want));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
        result_no = 0;
    end

    // Track transfers: predict on input, compare on output
    always @(posedge i_clk) begin
        t_tag want;
        if (!i_rst_n) begin
            phase = MSG_START;
            digit_count = '0;
            param_idx = '0;
            cr_seen = 1'b0;
            tag_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) tag_q.insert(tag_q.size(), tag_byte(i_in_byte));
            if (i_out_valid && !i_out_stall) begin
                if (tag_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d: byte %02h with nothing outstanding",
                                              result_no, i_char));
                end else begin
                    want = tag_q.pop_front();
                    check_field("char_out", i_char, want.ch);
                    check_field("field_kind", i_kind, want.kind);
                    check_field("param_number", i_pnum, want.pnum);
                    check_field("field_start", i_start, want.start);
                    check_field("bad_command", i_bad, want.bad);
                    check_field("too_many_digits", i_many, want.many);
                    check_field("message_done", i_done, want.done);
                    o_checked++;
                end
                result_no++;
            end
        end
        o_pending <= tag_q.size();
    end

endmodule

@@ dv/irc_message_tokenizer_top_tb.sv @@
// Testbench top for the IRC message tokenizer: clock, reset, byte stimulus,
// result-side stalls, watchdog and verdict. Depends on irc_tok_pkg, the block
// and irc_message_tokenizer_checker.
module irc_message_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS            = 1450;
    localparam int QUIET_AFTER      = ITEMS * 85 / 100;
    localparam int DRAIN_PAUSE_AT   = ITEMS / 2;
    localparam int LONG_HOLD_AFTER  = 300;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int SETTLE_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT   = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_char_out;
    logic [3:0] o_field_kind;
    logic [3:0] o_param_number;
    logic       o_field_start;
    logic       o_bad_command;
    logic       o_too_many_digits;
    logic       o_message_done;

    int fail_count;
    int pending;
    int checked;

    logic [7:0] tx_bytes[$];
    int         sent_count = 0;
    int         directed_count = 0;
    int         message_count = 0;
    int         noise_count = 0;
    logic       quiet;

    int   rx_count = 0;
    int   stall_left = 0;
    int   run_left = 0;
    logic long_hold_done = 1'b0;
    int   idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    irc_message_tokenizer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_char_out       (o_char_out),
        .o_field_kind     (o_field_kind),
        .o_param_number   (o_param_number),
        .o_field_start    (o_field_start),
        .o_bad_command    (o_bad_command),
        .o_too_many_digits(o_too_many_digits),
        .o_message_done   (o_message_done)
    );

    irc_message_tokenizer_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in_byte   (i_data_byte),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_char      (o_char_out),
        .i_kind      (o_field_kind),
        .i_pnum      (o_param_number),
        .i_start     (o_field_start),
        .i_bad       (o_bad_command),
        .i_many      (o_too_many_digits),
        .i_done      (o_message_done),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    // Append one byte to the transmit queue
    function automatic void queue_byte(input logic [7:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endfunction

    function automatic logic [7:0] pick_alpha();
        int unsigned v;
        v = $urandom_range(0, 51);
        return (v < 26) ? 8'(8'h41 + v) : 8'(8'h61 + v - 26);
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_nick_char();
        case ($urandom_range(0, 3))
            0: return pick_digit();
            1: begin
                // specials - [ ] \ ` ^ { } and '.'
                case ($urandom_range(0, 8))
                    0: return 8'h2D;
                    1: return 8'h5B;
                    2: return 8'h5D;
                    3: return 8'h5C;
                    4: return 8'h60;
                    5: return 8'h5E;
                    6: return 8'h7B;
                    7: return 8'h7D;
                    default: return 8'h2E;
                endcase
            end
            default: return pick_alpha();
        endcase
    endfunction

    // Any byte that cannot end a word or the line
    function automatic logic [7:0] pick_word_char(input logic no_at, input logic no_colon);
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while (b == irc_tok_pkg::CH_SPACE || b == irc_tok_pkg::CH_CR ||
                   b == irc_tok_pkg::CH_LF || (no_at && b == irc_tok_pkg::CH_AT) ||
                   (no_colon && b == irc_tok_pkg::CH_COLON));
        return b;
    endfunction

    // Trailing text: anything but a line end, spaces and NUL favoured
    function automatic logic [7:0] pick_text_char();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = irc_tok_pkg::CH_NUL;
            1: b = irc_tok_pkg::CH_SPACE;
            default: begin
                do b = 8'($urandom_range(0, 255));
                while (b == irc_tok_pkg::CH_CR || b == irc_tok_pkg::CH_LF);
            end
        endcase
        return b;
    endfunction

    // Build one message: optional prefix, command, parameters, line end
    task automatic compose_message();
        int unsigned n_params;
        if ($urandom_range(0, 1)) begin
            queue_byte(irc_tok_pkg::CH_COLON);
            if ($urandom_range(0, 9) == 0) begin
                queue_byte(pick_word_char(1'b0, 1'b0));
            end else begin
                queue_byte(pick_alpha());
                repeat ($urandom_range(0, 7)) queue_byte(pick_nick_char());
            end
            if ($urandom_range(0, 1)) begin
                queue_byte(irc_tok_pkg::CH_BANG);
                repeat ($urandom_range(1, 6)) queue_byte(pick_word_char(1'b1, 1'b0));
            end
            if ($urandom_range(0, 1)) begin
                queue_byte(irc_tok_pkg::CH_AT);
                repeat ($urandom_range(1, 8)) queue_byte(pick_word_char(1'b0, 1'b0));
            end
            repeat ($urandom_range(1, 3))
                queue_byte(($urandom_range(0, 5) == 0) ? irc_tok_pkg::CH_NUL
                                                       : irc_tok_pkg::CH_SPACE);
        end
        case ($urandom_range(0, 9))
            0: queue_byte(pick_digit());
            1: queue_byte(pick_word_char(1'b0, 1'b0));
            default: queue_byte(pick_alpha());
        endcase
        repeat ($urandom_range(0, 5)) queue_byte(pick_alpha());
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 6)) queue_byte(pick_digit());
        // now and then enough parameters to saturate the index
        n_params = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(0, 4);
        repeat (n_params) begin
            repeat (($urandom_range(0, 4) == 0) ? 2 : 1)
                queue_byte(($urandom_range(0, 7) == 0) ? irc_tok_pkg::CH_NUL
                                                       : irc_tok_pkg::CH_SPACE);
            queue_byte(pick_word_char(1'b0, 1'b1));
            repeat ($urandom_range(0, 6)) queue_byte(pick_word_char(1'b0, 1'b0));
        end
        if ($urandom_range(0, 1)) begin
            queue_byte(irc_tok_pkg::CH_SPACE);
            queue_byte(irc_tok_pkg::CH_COLON);
            repeat ($urandom_range(0, 12)) queue_byte(pick_text_char());
        end
        // drop the CR now and then so the LF stands alone
        if ($urandom_range(0, 15) != 0) queue_byte(irc_tok_pkg::CH_CR);
        queue_byte(irc_tok_pkg::CH_LF);
        message_count++;
    endtask

    // Short run of raw bytes, biased towards the ones the parser acts on
    task automatic compose_noise();
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(0, 7))
                0: queue_byte(irc_tok_pkg::CH_CR);
                1: queue_byte(irc_tok_pkg::CH_LF);
                2: queue_byte(irc_tok_pkg::CH_COLON);
                3: queue_byte(irc_tok_pkg::CH_SPACE);
                4: queue_byte(irc_tok_pkg::CH_NUL);
                default: queue_byte(8'($urandom_range(0, 255)));
            endcase
        end
        noise_count++;
    endtask

    // Offer one byte and hold it until the transfer happens
    task automatic send_byte(input logic [7:0] b);
        i_valid <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sent_count++;
    endtask

    task automatic send_queued(input logic gappy);
        while (tx_bytes.size() != 0) begin
            send_byte(tx_bytes.pop_front());
            if (gappy && !quiet && $urandom_range(0, 7) == 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait until every transfer has produced its result
    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold, none in the quiet tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) rx_count++;
            if (!long_hold_done && rx_count >= LONG_HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                i_stall <= 1'b1;
                stall_left--;
            end else begin
                i_stall <= 1'b0;
                if (run_left > 0) begin
                    run_left--;
                end else if (!quiet) begin
                    stall_left = $urandom_range(1, 10);
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                           : $urandom_range(0, 12);
                end
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("[irc_message_tokenizer_top] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic drained_once;
        drained_once = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data_byte <= '0;
        quiet <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: bare LF, full prefix, double gap, four digits, direct
        // parameter, trailing with NUL and a lone CR, bad digit command, 0xFF
        tx_bytes = '{irc_tok_pkg::CH_LF, irc_tok_pkg::CH_COLON, "a", irc_tok_pkg::CH_BANG,
                     "u", irc_tok_pkg::CH_AT, "h", irc_tok_pkg::CH_SPACE,
                     irc_tok_pkg::CH_SPACE, "X", "1", "2", "3", "4", "p",
                     irc_tok_pkg::CH_SPACE, irc_tok_pkg::CH_COLON, "t", irc_tok_pkg::CH_NUL,
                     irc_tok_pkg::CH_CR, "r", irc_tok_pkg::CH_CR, irc_tok_pkg::CH_LF, "9",
                     8'hFF, irc_tok_pkg::CH_CR, irc_tok_pkg::CH_LF};
        send_queued(1'b0);
        directed_count = sent_count;

        // Random: mostly well-formed messages, the rest noise
        while (sent_count < ITEMS) begin
            if ($urandom_range(0, 6) == 0) compose_noise();
            else compose_message();
            send_queued($urandom_range(0, 2) != 0);
            if (!drained_once && sent_count >= DRAIN_PAUSE_AT) begin
                drained_once = 1'b1;
                wait_drain();
            end
            if (sent_count >= QUIET_AFTER) quiet <= 1'b1;
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d bytes: %0d directed, %0d messages and %0d noise runs;",
                 sent_count, directed_count, message_count, noise_count);
        $display("%0d results checked, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("[irc_message_tokenizer_top] OK");
        end else begin
            $display("[irc_message_tokenizer_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/irc_tok_pkg.sv
design/irc_tok_parse.sv
design/irc_message_tokenizer_top.sv
dv/irc_message_tokenizer_checker.sv
dv/irc_message_tokenizer_top_tb.sv
